/* hdl/assert_macros.svh */
// Assertion macros shared by the address match RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wnam_pkg.sv */
// Package for the wildcard node address match core: sizes, codes, transaction types
// and the per-entry class compare. No dependencies.
`timescale 1ns / 1ps

package wnam_pkg;

    localparam int NODES = 64;
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = $clog2(NODES + 1);
    localparam logic [15:0] WILD = 16'hffff;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_EXACT = 2'd1;
    localparam logic [1:0] MODE_WILD  = 2'd2;

    typedef enum logic [2:0] {
        CLS_EXACT,
        CLS_POINT,
        CLS_NODE,
        CLS_NET,
        CLS_ALL,
        CLS_NONE
    } cls_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [15:0] zone;
        logic [15:0] net;
        logic [15:0] node;
        logic [15:0] point;
    } addr_t;

    typedef struct packed {
        logic        op;
        logic [1:0]  mode;
        logic [15:0] addr_zone;
        logic [15:0] addr_net;
        logic [15:0] addr_node;
        logic [15:0] addr_point;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] index;
        logic             found;
        logic             full_res;
    } result_t;

    // lookup token passed along the cell row
    typedef struct packed {
        logic             valid;
        addr_t            key;
        logic [1:0]       mode;
        cls_t             cls;
        logic [IDX_W-1:0] idx;
    } tok_t;

    // best class an entry hits for a key, among those the mode allows
    function automatic cls_t hit_class(addr_t e, addr_t a, logic [1:0] mode);
        logic [4:0] hit;
        cls_t       c;
        hit[0] = (e.zone == a.zone) && (e.net == a.net) &&
                 (e.node == a.node) && (e.point == a.point);
        hit[1] = (e.point == WILD) && (e.zone == a.zone) &&
                 (e.net == a.net) && (e.node == a.node);
        hit[2] = (e.node == WILD) && (e.zone == a.zone) && (e.net == a.net);
        hit[3] = (e.net == WILD) && (e.zone == a.zone);
        hit[4] = (e.zone == WILD);
        if (mode == MODE_WILD) begin
            hit[0] = 1'b0;
        end
        if (!(mode == MODE_FULL || mode == MODE_WILD)) begin
            hit[4:1] = 4'b0000;
        end
        if (hit[0]) begin
            c = CLS_EXACT;
        end else if (hit[1]) begin
            c = CLS_POINT;
        end else if (hit[2]) begin
            c = CLS_NODE;
        end else if (hit[3]) begin
            c = CLS_NET;
        end else if (hit[4]) begin
            c = CLS_ALL;
        end else begin
            c = CLS_NONE;
        end
        return c;
    endfunction

endpackage

/* hdl/wildcard_node_address_match_core.sv */
// Top level of the wildcard node address match core: control, entry count and cell row.
// Depends on wnam_pkg, wnam_cell and assert_macros.svh.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and cannot be held off. An append
// writes the entry in ST_APPEND and then raises done; a lookup ends when the lookup
// token, walking the row of NODES cells one cell per clock, leaves the last cell. busy is
// low again in the cycle that shows done, so the next transaction may be started then.

`include "assert_macros.svh"

module wildcard_node_address_match_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  wnam_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done,
    output wnam_pkg::result_t   result
);

    wnam_pkg::state_t                 state_reg;
    wnam_pkg::state_t                 state_next;
    logic [wnam_pkg::CNT_W-1:0]       count_reg;
    logic [wnam_pkg::CNT_W-1:0]       count_next;
    logic                             launch_reg;
    logic                             launch_next;
    logic                             done_reg;
    logic                             done_next;
    wnam_pkg::cmd_t                   req_reg;
    wnam_pkg::cmd_t                   req_next;
    wnam_pkg::result_t                result_reg;
    wnam_pkg::result_t                result_next;
    wnam_pkg::addr_t                  req_addr;
    logic                             is_full;
    wnam_pkg::tok_t                   chain [wnam_pkg::NODES+1];

    assign req_addr.zone  = req_reg.addr_zone;
    assign req_addr.net   = req_reg.addr_net;
    assign req_addr.node  = req_reg.addr_node;
    assign req_addr.point = req_reg.addr_point;
    assign is_full = (count_reg == wnam_pkg::CNT_W'(wnam_pkg::NODES));

    always_comb
    begin
        chain[0].valid = launch_reg;
        chain[0].key   = req_addr;
        chain[0].mode  = req_reg.mode;
        chain[0].cls   = wnam_pkg::CLS_NONE;
        chain[0].idx   = '0;
    end

    for (genvar i = 0; i < wnam_pkg::NODES; i++)
    begin : g_cell
        wnam_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .slot    (wnam_pkg::IDX_W'(i)),
            .live    (count_reg > wnam_pkg::CNT_W'(i)),
            .wr_en   ((state_reg == wnam_pkg::ST_APPEND) &&
                      (count_reg == wnam_pkg::CNT_W'(i))),
            .wr_data (req_addr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wnam_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.op == wnam_pkg::OP_APPEND) ? wnam_pkg::ST_APPEND
                                                                 : wnam_pkg::ST_SCAN;
                end
            end
            wnam_pkg::ST_APPEND:
            begin
                state_next = wnam_pkg::ST_IDLE;
            end
            wnam_pkg::ST_SCAN:
            begin
                if (chain[wnam_pkg::NODES].valid)
                begin
                    state_next = wnam_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wnam_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        busy        = (state_reg != wnam_pkg::ST_IDLE);
        count_next  = count_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        req_next    = req_reg;
        result_next = result_reg;
        case (state_reg)
            wnam_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next    = cmd;
                    launch_next = (cmd.op == wnam_pkg::OP_LOOKUP);
                end
            end
            wnam_pkg::ST_APPEND:
            begin
                done_next            = 1'b1;
                result_next.index    = count_reg;
                result_next.found    = 1'b0;
                result_next.full_res = is_full;
                if (!is_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            wnam_pkg::ST_SCAN:
            begin
                if (chain[wnam_pkg::NODES].valid)
                begin
                    done_next            = 1'b1;
                    result_next.full_res = 1'b0;
                    if (chain[wnam_pkg::NODES].cls != wnam_pkg::CLS_NONE)
                    begin
                        result_next.found = 1'b1;
                        result_next.index = wnam_pkg::CNT_W'(chain[wnam_pkg::NODES].idx);
                    end
                    else
                    begin
                        result_next.found = 1'b0;
                        result_next.index = count_reg;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wnam_pkg::ST_IDLE;
            count_reg  <= '0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n,
        count_reg <= wnam_pkg::CNT_W'(wnam_pkg::NODES), "entry count beyond table size")
    `ASSERT_IMPLY(a_found_in_table, clk, rst_n, done && result.found,
        (result.index < count_reg) && !result.full_res, "match outside written entries")
    `ASSERT_IMPLY(a_full_refusal, clk, rst_n, done && result.full_res,
        is_full, "append refused while table has room")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy,
        busy && !done, "accepted transaction did not hold busy")

endmodule

/* hdl/wnam_cell.sv */
// One table cell: holds a single address entry and updates the passing lookup token.
// Depends on wnam_pkg.
`timescale 1ns / 1ps

module wnam_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [wnam_pkg::IDX_W-1:0] slot,
    input  logic                      live,
    input  logic                      wr_en,
    input  wnam_pkg::addr_t           wr_data,
    input  wnam_pkg::tok_t            tok_in,
    output wnam_pkg::tok_t            tok_out
);

    wnam_pkg::addr_t entry_reg;
    wnam_pkg::addr_t entry_next;
    logic            tok_valid_reg;
    logic            tok_valid_next;
    wnam_pkg::tok_t  tok_reg;
    wnam_pkg::tok_t  tok_next;
    wnam_pkg::cls_t  own_cls;

    always_comb
    begin
        entry_next = wr_en ? wr_data : entry_reg;
    end

    always_comb
    begin
        own_cls  = live ? wnam_pkg::hit_class(entry_reg, tok_in.key, tok_in.mode)
                        : wnam_pkg::CLS_NONE;
        tok_next = tok_in;
        // strictly better class only: lower index keeps ties
        if (own_cls < tok_in.cls) begin
            tok_next.cls = own_cls;
            tok_next.idx = slot;
        end
        tok_valid_next = tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

/* verif/wnam_checker.sv */
// Checker for the wildcard node address match core: predicts each transaction's result
// and compares it with the result strobed on done. Depends on wnam_pkg.
`timescale 1ns / 1ps

module wnam_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  wnam_pkg::cmd_t    cmd,
    input  logic              done,
    input  wnam_pkg::result_t result,
    output logic              results_drained,
    output int                fail_count
);

    wnam_pkg::addr_t   entry_tab [wnam_pkg::NODES];
    int                entry_cnt;
    wnam_pkg::result_t owed_q [$];

    initial
    begin
        results_drained = 1'b1;
        fail_count      = 0;
        entry_cnt       = 0;
    end

    function automatic bit class_match(wnam_pkg::addr_t e, wnam_pkg::addr_t a,
                                       wnam_pkg::cls_t k);
        case (k)
            wnam_pkg::CLS_EXACT: return e == a;
            wnam_pkg::CLS_POINT: return e.point == wnam_pkg::WILD && e.zone == a.zone &&
                                        e.net == a.net && e.node == a.node;
            wnam_pkg::CLS_NODE:  return e.node == wnam_pkg::WILD && e.zone == a.zone &&
                                        e.net == a.net;
            wnam_pkg::CLS_NET:   return e.net == wnam_pkg::WILD && e.zone == a.zone;
            wnam_pkg::CLS_ALL:   return e.zone == wnam_pkg::WILD;
            default:             return 1'b0;
        endcase
    endfunction

    // updates the shadow table and returns the result the transaction should give
    function automatic wnam_pkg::result_t predict_result(wnam_pkg::cmd_t c);
        wnam_pkg::addr_t   a;
        wnam_pkg::result_t r;
        int                first_k;
        int                last_k;
        r       = '0;
        r.index = wnam_pkg::CNT_W'(entry_cnt);
        a       = '{c.addr_zone, c.addr_net, c.addr_node, c.addr_point};
        if (c.op == wnam_pkg::OP_APPEND)
        begin
            if (entry_cnt < wnam_pkg::NODES)
            begin
                entry_tab[entry_cnt] = a;
                entry_cnt++;
            end
            else
            begin
                r.full_res = 1'b1;
            end
        end
        else
        begin
            first_k = (c.mode == wnam_pkg::MODE_WILD) ? wnam_pkg::CLS_POINT
                                                      : wnam_pkg::CLS_EXACT;
            last_k  = (c.mode == wnam_pkg::MODE_FULL || c.mode == wnam_pkg::MODE_WILD)
                      ? wnam_pkg::CLS_ALL : wnam_pkg::CLS_EXACT;
            for (int k = first_k; k <= last_k && !r.found; k++)
            begin
                for (int i = 0; i < entry_cnt && !r.found; i++)
                begin
                    if (class_match(entry_tab[i], a, wnam_pkg::cls_t'(k)))
                    begin
                        r.found = 1'b1;
                        r.index = wnam_pkg::CNT_W'(i);
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wnam_pkg::result_t want;
        if (!rst_n)
        begin
            entry_cnt = 0;
            owed_q.delete();
            results_drained <= 1'b1;
        end
        else
        begin
            if (done)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("result with no transaction owed: index %0d", result.index);
                    fail_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (result.index !== want.index)
                    begin
                        $error("index: expected %0d, actual %0d", want.index, result.index);
                        fail_count++;
                    end
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, result.found);
                        fail_count++;
                    end
                    if (result.full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0d, actual %0d",
                               want.full_res, result.full_res);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                owed_q.push_back(predict_result(cmd));
            end
            results_drained <= (owed_q.size() == 0);
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the wildcard node address match core: clock, reset, stimulus, verdict.
// Depends on wnam_pkg, wildcard_node_address_match_core and wnam_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEMS     = 1400;
    localparam int CALM_TAIL = 150;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    wnam_pkg::cmd_t    cmd   = '0;
    logic              busy;
    logic              done;
    wnam_pkg::result_t result;
    logic              results_drained;
    int                fail_count;

    wnam_pkg::addr_t   appended_q [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    wildcard_node_address_match_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    wnam_checker match_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .done            (done),
        .result          (result),
        .results_drained (results_drained),
        .fail_count      (fail_count)
    );

    function automatic wnam_pkg::cmd_t mk_cmd(logic op, logic [1:0] mode, wnam_pkg::addr_t a);
        wnam_pkg::cmd_t c;
        c.op         = op;
        c.mode       = mode;
        c.addr_zone  = a.zone;
        c.addr_net   = a.net;
        c.addr_node  = a.node;
        c.addr_point = a.point;
        return c;
    endfunction

    function automatic wnam_pkg::cmd_t noise_cmd();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bits[$bits(wnam_pkg::cmd_t)-1:0];
    endfunction

    // entry parts lean on a small pool and wildcards so that lookups hit
    function automatic logic [15:0] entry_part();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 4)
            return 16'($urandom_range(1, 3));
        else if (r <= 6)
            return wnam_pkg::WILD;
        else if (r == 7)
            return 16'd0;
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] key_part();
        int r;
        r = $urandom_range(0, 7);
        if (r <= 3)
            return 16'($urandom_range(1, 3));
        else if (r == 4)
            return wnam_pkg::WILD;
        else if (r == 5)
            return 16'd0;
        return 16'($urandom());
    endfunction

    // key derived from a stored entry, wildcard parts filled in, some parts disturbed
    function automatic wnam_pkg::addr_t near_key();
        wnam_pkg::addr_t a;
        a = appended_q[$urandom_range(0, appended_q.size() - 1)];
        if (a.zone == wnam_pkg::WILD || $urandom_range(0, 7) == 0)
            a.zone = key_part();
        if (a.net == wnam_pkg::WILD || $urandom_range(0, 7) == 0)
            a.net = key_part();
        if (a.node == wnam_pkg::WILD || $urandom_range(0, 7) == 0)
            a.node = key_part();
        if (a.point == wnam_pkg::WILD || $urandom_range(0, 7) == 0)
            a.point = key_part();
        return a;
    endfunction

    function automatic wnam_pkg::cmd_t random_cmd();
        wnam_pkg::addr_t a;
        logic [1:0]      mode;
        mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0)
        begin
            a = '{entry_part(), entry_part(), entry_part(), entry_part()};
            return mk_cmd(wnam_pkg::OP_APPEND, mode, a);
        end
        if (appended_q.size() > 0 && $urandom_range(0, 4) != 0)
            a = near_key();
        else
            a = '{key_part(), key_part(), key_part(), key_part()};
        return mk_cmd(wnam_pkg::OP_LOOKUP, mode, a);
    endfunction

    task automatic send_txn(wnam_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (c.op == wnam_pkg::OP_APPEND && appended_q.size() < wnam_pkg::NODES)
            appended_q.push_back(wnam_pkg::addr_t'{c.addr_zone, c.addr_net,
                                                   c.addr_node, c.addr_point});
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n)
        begin
            cmd <= noise_cmd();
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (!results_drained);
    endtask

    initial
    begin
        wnam_pkg::cmd_t plan [$];
        bit             calm;
        int             gap;
        calm = 1'b0;

        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, MODE_SPARE,
                              '{wnam_pkg::WILD, wnam_pkg::WILD, wnam_pkg::WILD,
                                wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_EXACT,
                              '{16'd1, 16'd1, 16'd1, wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_WILD,
                              '{16'd1, 16'd1, wnam_pkg::WILD, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, MODE_SPARE,
                              '{16'd1, wnam_pkg::WILD, 16'd0, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_FULL,
                              '{wnam_pkg::WILD, 16'd0, 16'd0, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_FULL,
                              '{16'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_EXACT,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_WILD,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, MODE_SPARE,
                              '{16'd1, 16'd1, 16'd1, 16'd1}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd1, 16'd5}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd7, 16'd5}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd9, 16'd7, 16'd5}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd3, 16'd9, 16'd7, 16'd5}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_EXACT,
                              '{16'd3, 16'd9, 16'd7, 16'd5}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd1, 16'd1, 16'd1, wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_WILD,
                              '{wnam_pkg::WILD, wnam_pkg::WILD, wnam_pkg::WILD,
                                wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_APPEND, wnam_pkg::MODE_FULL,
                              '{wnam_pkg::WILD, wnam_pkg::WILD, wnam_pkg::WILD,
                                wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_EXACT,
                              '{wnam_pkg::WILD, wnam_pkg::WILD, wnam_pkg::WILD,
                                wnam_pkg::WILD}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_WILD,
                              '{16'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(mk_cmd(wnam_pkg::OP_LOOKUP, wnam_pkg::MODE_FULL,
                              '{16'd0, 16'd0, 16'd0, 16'd0}));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_txn(plan[i]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 9));
        end
        wait_drained();

        // table fills part way through, later appends are refused
        for (int i = 0; i < ITEMS; i++)
        begin
            if (i % 60 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i == ITEMS / 2)
                wait_drained();
            send_txn(random_cmd());
            gap = 0;
            if (i < ITEMS - CALM_TAIL && !calm && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 9);
            if (gap > 0)
                idle_gap(gap);
        end

        wait_drained();
        repeat (wnam_pkg::NODES + 8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
